// File: design/hcbd_pkg.sv
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam int COUNT_BITS_DEFAULT = 31;
  localparam int FIFO_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_DATA,
    PH_AFTER,
    PH_AFTER_CR,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ST_ZERO_CHUNK,
    ST_BETWEEN,
    ST_TRUNCATED,
    ST_PARSE_ERROR
  } end_status_t;

  typedef struct packed {
    logic        has_payload;
    logic        has_status;
    logic [7:0]  data;
    end_status_t status;
  } entry_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

endpackage

// File: design/hcbd_front.sv
`timescale 1ns / 1ps

module hcbd_front #(
  parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            full,
  input  logic [7:0]      in_byte,
  input  logic            end_of_body,
  output logic            push,
  output hcbd_pkg::entry_t push_entry
);

  hcbd_pkg::phase_t phase, phase_next, phase_step;
  logic [COUNT_BITS-1:0] size_acc, size_acc_next;
  logic [COUNT_BITS-1:0] remaining, remaining_next;
  logic digit_seen, digit_seen_next;
  logic trail_space, trail_space_next;
  logic pend_cr, pend_cr_next;
  logic accept;

  assign accept = in_valid && !full;

  always_comb begin
    logic                  run_size;
    logic                  clear;
    logic [COUNT_BITS-1:0] l_acc;
    logic                  l_ds;
    logic                  l_ts;
    logic                  l_pcr;
    logic                  ts_work;
    hcbd_pkg::hex_t        hx;
    phase_step       = phase;
    size_acc_next    = size_acc;
    remaining_next   = remaining;
    digit_seen_next  = digit_seen;
    trail_space_next = trail_space;
    pend_cr_next     = pend_cr;
    run_size         = 1'b0;
    clear            = 1'b0;
    hx               = hcbd_pkg::hex_digit(in_byte);
    unique case (phase)
      hcbd_pkg::PH_DATA: begin
        remaining_next = remaining - COUNT_BITS'(1);
        if (remaining == COUNT_BITS'(1)) begin
          phase_step = hcbd_pkg::PH_AFTER;
        end
      end
      hcbd_pkg::PH_AFTER: begin
        if (in_byte == hcbd_pkg::CH_CR) begin
          phase_step = hcbd_pkg::PH_AFTER_CR;
        end else begin
          run_size = 1'b1;
          clear    = 1'b1;
        end
      end
      hcbd_pkg::PH_AFTER_CR: begin
        phase_step       = hcbd_pkg::PH_SIZE;
        size_acc_next    = '0;
        digit_seen_next  = 1'b0;
        trail_space_next = 1'b0;
        pend_cr_next     = 1'b0;
        run_size         = (in_byte != hcbd_pkg::CH_LF);
        clear            = 1'b1;
      end
      hcbd_pkg::PH_SIZE: begin
        run_size = 1'b1;
      end
      default: begin
      end
    endcase

    l_acc   = clear ? '0 : size_acc;
    l_ds    = clear ? 1'b0 : digit_seen;
    l_ts    = clear ? 1'b0 : trail_space;
    l_pcr   = clear ? 1'b0 : pend_cr;
    ts_work = l_ts;

    if (run_size) begin
      phase_step       = hcbd_pkg::PH_SIZE;
      size_acc_next    = l_acc;
      digit_seen_next  = l_ds;
      pend_cr_next     = 1'b0;
      if (l_pcr && in_byte == hcbd_pkg::CH_LF) begin
        if (!l_ds) begin
          phase_step = hcbd_pkg::PH_ERROR;
        end else if (l_acc == '0) begin
          phase_step = hcbd_pkg::PH_DONE;
        end else begin
          remaining_next = l_acc;
          phase_step     = hcbd_pkg::PH_DATA;
        end
        size_acc_next    = '0;
        digit_seen_next  = 1'b0;
        trail_space_next = 1'b0;
      end else begin
        if (l_pcr && l_ds) begin
          ts_work = 1'b1;
        end
        trail_space_next = ts_work;
        if (in_byte == hcbd_pkg::CH_CR) begin
          pend_cr_next = 1'b1;
        end else if (hx.valid) begin
          if (ts_work || (l_acc[COUNT_BITS-1 -: 4] != 4'd0)) begin
            phase_step       = hcbd_pkg::PH_ERROR;
            size_acc_next    = '0;
            digit_seen_next  = 1'b0;
            trail_space_next = 1'b0;
          end else begin
            size_acc_next   = {l_acc[COUNT_BITS-5:0], hx.value};
            digit_seen_next = 1'b1;
          end
        end else if (hcbd_pkg::is_space(in_byte)) begin
          if (l_ds) begin
            trail_space_next = 1'b1;
          end
        end else begin
          phase_step       = hcbd_pkg::PH_ERROR;
          size_acc_next    = '0;
          digit_seen_next  = 1'b0;
          trail_space_next = 1'b0;
        end
      end
    end

    phase_next = phase_step;
    if (end_of_body) begin
      phase_next       = hcbd_pkg::PH_SIZE;
      size_acc_next    = '0;
      remaining_next   = '0;
      digit_seen_next  = 1'b0;
      trail_space_next = 1'b0;
      pend_cr_next     = 1'b0;
    end
  end

  always_comb begin
    push                   = accept && ((phase == hcbd_pkg::PH_DATA) || end_of_body);
    push_entry.has_payload = (phase == hcbd_pkg::PH_DATA);
    push_entry.has_status  = end_of_body;
    push_entry.data        = in_byte;
    unique case (phase_step)
      hcbd_pkg::PH_DONE:  push_entry.status = hcbd_pkg::ST_ZERO_CHUNK;
      hcbd_pkg::PH_ERROR: push_entry.status = hcbd_pkg::ST_PARSE_ERROR;
      hcbd_pkg::PH_DATA:  push_entry.status = hcbd_pkg::ST_TRUNCATED;
      default:            push_entry.status = hcbd_pkg::ST_BETWEEN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= hcbd_pkg::PH_SIZE;
      size_acc    <= '0;
      remaining   <= '0;
      digit_seen  <= 1'b0;
      trail_space <= 1'b0;
      pend_cr     <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      size_acc    <= size_acc_next;
      remaining   <= remaining_next;
      digit_seen  <= digit_seen_next;
      trail_space <= trail_space_next;
      pend_cr     <= pend_cr_next;
    end
  end

  a_data_has_count: assert property (@(posedge clk) disable iff (rst)
    (phase == hcbd_pkg::PH_DATA) |-> (remaining != '0))
    else $error("data phase entered with a zero byte count");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("transaction pushed into a full queue");

  a_eob_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_body) |=> (phase == hcbd_pkg::PH_SIZE) && (remaining == '0))
    else $error("decoder did not return to its reset state after end of body");

endmodule

// File: design/hcbd_fifo.sv
`timescale 1ns / 1ps

module hcbd_fifo #(
  parameter int DEPTH = hcbd_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hcbd_pkg::entry_t push_entry,
  input  logic             pop,
  output hcbd_pkg::entry_t head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hcbd_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("transaction popped from an empty queue");

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (head.has_payload || head.has_status))
    else $error("queued transaction carries no result");

endmodule

// File: design/hcbd_back.sv
`timescale 1ns / 1ps

module hcbd_back (
  input  logic             clk,
  input  logic             rst,
  input  hcbd_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             item_kind,
  output logic [1:0]       end_status,
  output logic             run_last
);

  logic second, second_next;
  logic show_status;
  logic take;

  assign out_valid   = !empty;
  assign show_status = head.has_status && (!head.has_payload || second);
  assign item_kind   = show_status;
  assign out_byte    = show_status ? 8'd0 : head.data;
  assign end_status  = show_status ? 2'(head.status) : 2'd0;
  assign run_last    = show_status || !head.has_status;
  assign take        = out_valid && !out_stall;
  assign pop         = take && run_last;

  always_comb begin
    second_next = second;
    if (take) begin
      second_next = !run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else begin
      second <= second_next;
    end
  end

  a_second_pair: assert property (@(posedge clk) disable iff (rst)
    second |-> (!empty && head.has_payload && head.has_status))
    else $error("second result pending on a transaction without two results");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (take && !run_last) |=> (item_kind && run_last))
    else $error("status result did not follow its payload byte");

endmodule

// File: design/http_chunked_body_decoder.sv
`timescale 1ns / 1ps

// Chunked transfer decoder for an HTTP/1.1 body. It accepts one body byte per clock
// when in_stall is low and passes chunk data bytes out as they arrive, dropping the size
// lines and the CR LF after each chunk; on the byte marked end_of_body one status result
// follows any payload byte from that byte, and the decoder returns to its reset state.
// The size-line parser updates its state as each byte is accepted; the output side gives
// one result per clock when out_stall is low, so the byte ending the body inside chunk
// data yields two results, which a queue of FIFO_DEPTH transactions absorbs. Chunk sizes
// above 2^COUNT_BITS-1 are reported as parse errors.
module http_chunked_body_decoder #(
  parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEFAULT,
  parameter int FIFO_DEPTH = hcbd_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_body,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       item_kind,
  output logic [1:0] end_status,
  output logic       run_last
);

  logic             push, pop, empty, full;
  hcbd_pkg::entry_t push_entry, head;

  assign in_stall = full;

  hcbd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .full(full),
    .in_byte(in_byte),
    .end_of_body(end_of_body),
    .push(push),
    .push_entry(push_entry)
  );

  hcbd_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(pop),
    .head(head),
    .empty(empty),
    .full(full)
  );

  hcbd_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .empty(empty),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .item_kind(item_kind),
    .end_status(end_status),
    .run_last(run_last)
  );

endmodule

// File: tb/tb_http_chunked_body_decoder.sv
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;

  localparam int          COUNT_BITS  = hcbd_pkg::COUNT_BITS_DEFAULT;
  localparam logic [63:0] COUNT_MASK  = (64'd1 << COUNT_BITS) - 64'd1;
  localparam int          BODY_BYTES  = 1650;
  localparam int          QUIET_ITEMS = 150;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          SETTLE      = 20;

  localparam logic        KIND_PAYLOAD = 1'b0;
  localparam logic        KIND_STATUS  = 1'b1;

  localparam logic [7:0]  CH_SP  = 8'h20;
  localparam logic [7:0]  CH_TAB = 8'h09;
  localparam logic [7:0]  CH_VT  = 8'h0B;
  localparam logic [7:0]  CH_FF  = 8'h0C;

  typedef struct {
    logic [7:0] data;
    logic       eob;
  } body_byte_t;

  typedef struct {
    logic [7:0]            data;
    logic                  kind;
    hcbd_pkg::end_status_t status;
    logic                  last;
  } dec_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_body = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       item_kind;
  logic [1:0] end_status;
  logic       run_last;

  body_byte_t  body_bytes_q[$];
  logic [7:0]  body_q[$];
  dec_result_t decoded_q[$];

  int total_bytes = 0;
  int bytes_taken = 0;
  int fails = 0;
  int in_gap = 0;
  int out_gap = 0;
  int cycles = 0;

  hcbd_pkg::phase_t dec_phase;
  logic [63:0]      dec_acc;
  logic [63:0]      dec_left;
  logic             dec_digit;
  logic             dec_trail;
  logic             dec_cr;

  http_chunked_body_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .end_of_body(end_of_body),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .item_kind  (item_kind),
    .end_status (end_status),
    .run_last   (run_last)
  );

  always #4 clk = ~clk;

  function automatic int nibble_of(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  task automatic reset_line();
    dec_acc = 64'd0;
    dec_digit = 1'b0;
    dec_trail = 1'b0;
    dec_cr = 1'b0;
  endtask

  task automatic reset_decoder();
    dec_phase = hcbd_pkg::PH_SIZE;
    dec_left = 64'd0;
    reset_line();
  endtask

  task automatic scan_size_char(logic [7:0] b);
    int d;
    d = nibble_of(b);
    if (dec_cr) begin
      dec_cr = 1'b0;
      if (b == hcbd_pkg::CH_LF) begin
        if (!dec_digit) begin
          dec_phase = hcbd_pkg::PH_ERROR;
        end else if (dec_acc == 64'd0) begin
          dec_phase = hcbd_pkg::PH_DONE;
        end else begin
          dec_left = dec_acc & COUNT_MASK;
          dec_phase = hcbd_pkg::PH_DATA;
        end
        reset_line();
        return;
      end
      if (dec_digit) dec_trail = 1'b1;
    end
    if (b == hcbd_pkg::CH_CR) begin
      dec_cr = 1'b1;
    end else if (d >= 0) begin
      if (dec_trail || dec_acc > (COUNT_MASK >> 4)) begin
        dec_phase = hcbd_pkg::PH_ERROR;
        reset_line();
      end else begin
        dec_acc = (dec_acc << 4) | 64'(d);
        dec_digit = 1'b1;
      end
    end else if (b == CH_SP || (b >= CH_TAB && b <= hcbd_pkg::CH_CR)) begin
      if (dec_digit) dec_trail = 1'b1;
    end else begin
      dec_phase = hcbd_pkg::PH_ERROR;
      reset_line();
    end
  endtask

  task automatic decode_byte(logic [7:0] b, logic eob);
    dec_result_t res[2];
    hcbd_pkg::end_status_t st;
    int n;
    n = 0;
    case (dec_phase)
      hcbd_pkg::PH_DATA: begin
        res[0] = '{data: b, kind: KIND_PAYLOAD, status: hcbd_pkg::ST_ZERO_CHUNK,
                   last: 1'b0};
        n = 1;
        dec_left = (dec_left - 64'd1) & COUNT_MASK;
        if (dec_left == 64'd0) dec_phase = hcbd_pkg::PH_AFTER;
      end
      hcbd_pkg::PH_AFTER: begin
        if (b == hcbd_pkg::CH_CR) begin
          dec_phase = hcbd_pkg::PH_AFTER_CR;
        end else begin
          dec_phase = hcbd_pkg::PH_SIZE;
          reset_line();
          scan_size_char(b);
        end
      end
      hcbd_pkg::PH_AFTER_CR: begin
        dec_phase = hcbd_pkg::PH_SIZE;
        reset_line();
        if (b != hcbd_pkg::CH_LF) scan_size_char(b);
      end
      hcbd_pkg::PH_SIZE: scan_size_char(b);
      default: ;
    endcase
    if (eob) begin
      case (dec_phase)
        hcbd_pkg::PH_DONE:  st = hcbd_pkg::ST_ZERO_CHUNK;
        hcbd_pkg::PH_ERROR: st = hcbd_pkg::ST_PARSE_ERROR;
        hcbd_pkg::PH_DATA:  st = hcbd_pkg::ST_TRUNCATED;
        default:            st = hcbd_pkg::ST_BETWEEN;
      endcase
      res[n] = '{data: 8'h00, kind: KIND_STATUS, status: st, last: 1'b0};
      n++;
      reset_decoder();
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) decoded_q.push_back(res[i]);
  endtask

  task automatic end_body();
    logic [7:0] b;
    while (body_q.size() > 0) begin
      b = body_q.pop_front();
      body_bytes_q.push_back('{data: b, eob: body_q.size() == 0});
      total_bytes++;
    end
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  task automatic add_crlf();
    body_q.push_back(hcbd_pkg::CH_CR);
    body_q.push_back(hcbd_pkg::CH_LF);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 4))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_VT;
      3: return CH_FF;
      default: return hcbd_pkg::CH_LF;
    endcase
  endfunction

  task automatic add_size_line(logic [63:0] val);
    int nd;
    nd = 1;
    for (int k = 1; k < 16; k++) if ((val >> (4 * k)) != 64'd0) nd = k + 1;
    if ($urandom_range(0, 3) == 0) nd += $urandom_range(1, 2);
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 5) == 0) begin
        body_q.push_back(hcbd_pkg::CH_CR);
        body_q.push_back(CH_SP);
      end else begin
        body_q.push_back(pick_space());
      end
    end
    for (int k = nd - 1; k >= 0; k--) begin
      body_q.push_back(hex_char(4'(val >> (4 * k)), $urandom_range(0, 1)));
    end
    if ($urandom_range(0, 3) == 0) body_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
    add_crlf();
  endtask

  task automatic gen_body();
    logic [63:0] sz;
    int chunks;
    int pick;
    int cut;
    bit stop;
    stop = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) body_q.push_back(8'($urandom));
    end else begin
      chunks = $urandom_range(0, 4);
      for (int k = 0; k < chunks && !stop; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 16) sz = 64'($urandom_range(1, 24));
        else if (pick < 18) sz = 64'($urandom_range(25, 200));
        else if (pick == 18) sz = 64'(31'($urandom)) | 64'h100;
        else sz = {32'd0, 1'b1, 31'($urandom)};
        add_size_line(sz);
        if (sz > 64'd200) begin
          repeat ($urandom_range(0, 5)) body_q.push_back(8'($urandom));
          stop = 1'b1;
        end else begin
          repeat (sz) body_q.push_back(8'($urandom));
          pick = $urandom_range(0, 7);
          if (pick < 6) add_crlf();
          else if (pick == 6) body_q.push_back(hcbd_pkg::CH_CR);
        end
      end
      if (!stop && $urandom_range(0, 4) != 0) begin
        add_size_line(64'd0);
        repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom));
      end
    end
    if ($urandom_range(0, 7) == 0 && body_q.size() > 0) begin
      body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom);
    end
    if ($urandom_range(0, 7) == 0 && body_q.size() > 1) begin
      cut = $urandom_range(1, body_q.size() - 1);
      while (body_q.size() > cut) void'(body_q.pop_back());
    end
    if (body_q.size() == 0) body_q.push_back(8'($urandom));
    end_body();
  endtask

  // Driver: one transaction per accepted byte; the predictor runs at acceptance.
  always @(posedge clk) begin
    body_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte, end_of_body);
        bytes_taken++;
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (body_bytes_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (body_bytes_q.size() > QUIET_ITEMS && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else begin
        nxt = body_bytes_q.pop_front();
        in_byte <= nxt.data;
        end_of_body <= nxt.eob;
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor: checks each accepted result transaction against the oldest expectation.
  always @(posedge clk) begin
    dec_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected result: byte %02h kind %0d status %0d last %0d",
                     out_byte, item_kind, end_status, run_last);
          end
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data || item_kind !== want.kind ||
              end_status !== want.status || run_last !== want.last) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: want %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                       want.data, want.kind, want.status, want.last,
                       out_byte, item_kind, end_status, run_last);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (body_bytes_q.size() > QUIET_ITEMS && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("http_chunked_body_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    reset_decoder();

    // Lone CR as whitespace, trailing space, CR then a digit right after a chunk.
    body_q.push_back(hcbd_pkg::CH_CR);
    add_text("1 ");
    add_crlf();
    body_q.push_back(8'hFF);
    body_q.push_back(hcbd_pkg::CH_CR);
    add_text("A");
    end_body();
    // Zero chunk followed by an ignored byte.
    add_text("0");
    add_crlf();
    add_text("q");
    end_body();
    // Digit after trailing whitespace, hex prefix, sign, empty line, overflow.
    add_text("1 2");
    end_body();
    add_text("0x");
    end_body();
    add_text("-");
    end_body();
    add_crlf();
    end_body();
    add_text("80000000");
    end_body();
    // Body ends inside chunk data.
    add_text("2");
    add_crlf();
    body_q.push_back(8'h00);
    end_body();

    while (total_bytes < BODY_BYTES) gen_body();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < total_bytes) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fails == 0 && decoded_q.size() == 0) begin
      $display("http_chunked_body_decoder regression: pass");
    end else begin
      if (decoded_q.size() != 0) $display("%0d expected results never arrived", decoded_q.size());
      $display("http_chunked_body_decoder regression: fail");
    end
    $finish;
  end

endmodule
